### design/rtcdc_pkg.sv
// ----------------------------------------------------------------------------
// rtcdc_pkg : shared types and helpers for the rtc date/time check and pack
// beat structs, calendar constants, bcd and weekday helper functions
// ----------------------------------------------------------------------------
package rtcdc_pkg;

    localparam logic [13:0] YEAR_MIN        = 14'd2000;
    localparam logic [13:0] YEAR_MAX        = 14'd2099;
    localparam logic [13:0] TWO_DIGIT_LIMIT = 14'd100;
    localparam logic [4:0]  FEB_LEAP_DAYS   = 5'd29;
    localparam logic [4:0]  HOUR_MAX        = 5'd23;
    localparam logic [5:0]  MINSEC_MAX      = 6'd59;
    localparam logic [3:0]  MONTH_MAX       = 4'd12;
    localparam logic [6:0]  CENTURY_BCD     = 7'h20;
    localparam logic [2:0]  WEEKDAY_MOD     = 3'd7;

    typedef struct packed {
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } t_rtcdc_in;

    typedef struct packed {
        logic        status;
        logic [21:0] time_word;
        logic [29:0] calendar_word;
        logic [2:0]  weekday;
    } t_rtcdc_out;

    // binary 0..99 to two bcd digits
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [3:0] tens;
        logic [6:0] ones;
        tens = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 7'(k * 10)) begin
                tens = 4'(k);
            end
        end
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

    // month length, zero for a month code outside 1..12
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
            4'd2:    d = leap ? FEB_LEAP_DAYS : 5'd28;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // month contribution to the weekday sum, mod 7, with the year offset folded in
    function automatic logic [2:0] month_term(input logic [3:0] m);
        logic [2:0] t;
        unique case (m)
            4'd1:    t = 3'd1;
            4'd2:    t = 3'd4;
            4'd3:    t = 3'd3;
            4'd4:    t = 3'd6;
            4'd5:    t = 3'd1;
            4'd6:    t = 3'd4;
            4'd7:    t = 3'd6;
            4'd8:    t = 3'd2;
            4'd9:    t = 3'd5;
            4'd10:   t = 3'd0;
            4'd11:   t = 3'd3;
            4'd12:   t = 3'd5;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    // x mod 7 by folding base-8 digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        s1 = 6'(x[7:3]) + 6'(x[2:0]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 3'(s2[3]) + s2[2:0];
        return (s3 == WEEKDAY_MOD) ? 3'd0 : s3;
    endfunction

endpackage

### design/rtcdc_eval.sv
// ----------------------------------------------------------------------------
// rtcdc_eval : date/time validation, weekday and bcd packing
// single-pass combinational evaluation of one registered beat
// ----------------------------------------------------------------------------
module rtcdc_eval (
    input  rtcdc_pkg::t_rtcdc_in  i_item,
    output rtcdc_pkg::t_rtcdc_out o_result
);

    logic       two_digit;
    logic       in_window;
    logic       year_ok;
    logic [6:0] yy;
    logic       leap;
    logic [4:0] mdays;
    logic       month_ok;
    logic       day_ok;
    logic       time_ok;
    logic       early;
    logic [6:0] u;
    logic [7:0] wsum;
    logic [2:0] wd;
    logic       ok;
    logic [7:0] sec_bcd;
    logic [7:0] min_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] mon_bcd;
    logic [7:0] day_bcd;
    logic [7:0] yy_bcd;

    always_comb begin
        two_digit = i_item.year_in < rtcdc_pkg::TWO_DIGIT_LIMIT;
        in_window = (i_item.year_in >= rtcdc_pkg::YEAR_MIN)
                    && (i_item.year_in <= rtcdc_pkg::YEAR_MAX);
        year_ok   = two_digit || in_window;
        yy        = two_digit ? i_item.year_in[6:0]
                              : 7'(i_item.year_in - rtcdc_pkg::YEAR_MIN);

        // within 2000..2099 only the divisible-by-4 rule matters (2000 is a leap year)
        leap      = (yy[1:0] == 2'd0);
        mdays     = rtcdc_pkg::month_days(i_item.month_in, leap);
        month_ok  = (i_item.month_in != 4'd0) && (i_item.month_in <= rtcdc_pkg::MONTH_MAX);
        day_ok    = (i_item.day_in != 5'd0) && (i_item.day_in <= mdays);
        time_ok   = (i_item.hour_in <= rtcdc_pkg::HOUR_MAX)
                    && (i_item.minute_in <= rtcdc_pkg::MINSEC_MAX)
                    && (i_item.second_in <= rtcdc_pkg::MINSEC_MAX);
        ok        = year_ok && month_ok && day_ok && time_ok;

        // january and february count in the previous year; u is that year offset plus 4
        early     = (i_item.month_in <= 4'd2);
        u         = yy + (early ? 7'd3 : 7'd4);
        wsum      = 8'(i_item.day_in) + 8'(rtcdc_pkg::month_term(i_item.month_in))
                    + 8'(u) + 8'(u[6:2]);
        wd        = rtcdc_pkg::mod7(wsum) + 3'd1;

        sec_bcd   = rtcdc_pkg::to_bcd(7'(i_item.second_in));
        min_bcd   = rtcdc_pkg::to_bcd(7'(i_item.minute_in));
        hour_bcd  = rtcdc_pkg::to_bcd(7'(i_item.hour_in));
        mon_bcd   = rtcdc_pkg::to_bcd(7'(i_item.month_in));
        day_bcd   = rtcdc_pkg::to_bcd(7'(i_item.day_in));
        yy_bcd    = rtcdc_pkg::to_bcd(yy);

        if (ok) begin
            o_result.status        = 1'b0;
            o_result.weekday       = wd;
            o_result.time_word     = {hour_bcd[5:0], 1'b0,
                                      min_bcd[6:0], 1'b0,
                                      sec_bcd[6:0]};
            o_result.calendar_word = {day_bcd[5:0],
                                      wd,
                                      mon_bcd[4:0],
                                      yy_bcd,
                                      1'b0,
                                      rtcdc_pkg::CENTURY_BCD};
        end else begin
            o_result.status        = 1'b1;
            o_result.weekday       = 3'd0;
            o_result.time_word     = 22'd0;
            o_result.calendar_word = 30'd0;
        end
    end

endmodule

### design/rtc_datetime_check_and_pack_unit.sv
// ----------------------------------------------------------------------------
// rtc_datetime_check_and_pack_unit : rtc date/time check and register pack
// validates a date and time, derives the weekday and packs bcd rtc words
// ----------------------------------------------------------------------------
// an accepted input beat goes through the input register, eval and the result register to the output
// throughput: one beat per cycle while the output is not stalled, set by that register path
// a stalled output holds both stages; the input is stalled only when both are full
// and the output is stalled
// reset: synchronous active-low i_rst_n clears both stage valid flags, payloads are not reset
// ----------------------------------------------------------------------------
module rtc_datetime_check_and_pack_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rtcdc_pkg::t_rtcdc_in  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rtcdc_pkg::t_rtcdc_out o_out_data
);

    // stage 1: input register
    logic                  r_s1_vld;
    rtcdc_pkg::t_rtcdc_in  r_s1_data;
    // stage 2: result register
    logic                  r_out_vld;
    rtcdc_pkg::t_rtcdc_out r_out_data;

    rtcdc_pkg::t_rtcdc_out eval_result;
    logic                  s2_advance;
    logic                  s1_load;

    // result register moves when it is empty or its beat is being taken
    assign s2_advance = !(r_out_vld && i_out_stall);
    // input register takes a new beat when empty or when it is moving on
    assign s1_load    = !r_s1_vld || s2_advance;
    assign o_in_stall = !s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_load) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
    end

    rtcdc_eval u_eval (
        .i_item   (r_s1_data),
        .o_result (eval_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_advance) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_advance && r_s1_vld) begin
            r_out_data <= eval_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // error beats carry all-zero words
    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_data.status) |->
            (r_out_data.time_word == 22'd0) && (r_out_data.calendar_word == 30'd0)
            && (r_out_data.weekday == 3'd0))
        else $error("error beat with nonzero words");

    // good beats carry a weekday 1..7 that matches the calendar word field
    a_wd_consistent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_data.status) |->
            (r_out_data.weekday != 3'd0)
            && (r_out_data.calendar_word[23:21] == r_out_data.weekday))
        else $error("weekday out of range or not packed");

    // good beats always carry century 20
    a_century : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_data.status) |->
            (r_out_data.calendar_word[6:0] == rtcdc_pkg::CENTURY_BCD))
        else $error("century field wrong");

    // input register never drops a beat while the output is stalled
    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && i_out_stall) |=> r_s1_vld)
        else $error("stage 1 beat lost under output stall");

endmodule
